/* src/servo_channel_allocate_and_duty_unit_defines.svh */
// assertion macros for the servo channel unit checker
`ifndef SERVO_CHANNEL_ALLOCATE_AND_DUTY_UNIT_DEFINES_SVH
`define SERVO_CHANNEL_ALLOCATE_AND_DUTY_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SCAD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scad assertion failed");

// next-cycle implication, disabled in reset
`define SCAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scad assertion failed");

`endif

/* src/scad_pkg.sv */
// types and constants of the servo channel allocate and duty unit
package scad_pkg;

  localparam int PIN_W       = 6;
  localparam int ANGLE_W     = 10;
  localparam int STATUS_W    = 2;
  localparam int CHAN_W      = 3;
  localparam int DUTY_W      = 10;
  localparam int ANGLE_MAG_W = 8;
  localparam int PULSE_W     = 12;

  localparam int ANGLE_LIMIT = 180;
  localparam int PULSE_MIN   = 500;
  localparam int DUTY_MIN    = 204;

  // shared multiplier sizing
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = 51;

  // angle*2000/180 as angle*728200 >> 16, exact for angle up to 180
  localparam int ANGLE_RECIP = 728200;
  localparam int ANGLE_SHIFT = 16;
  localparam int DUTY_FULL   = 8191;
  // n/20000 as n*ceil(2^40/20000) >> 40, exact for n below 2^25
  localparam longint PERIOD_RECIP = 64'd54975582;
  localparam int PERIOD_SHIFT     = 40;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MUL_ANGLE  = 2'd0,
    MUL_FULL   = 2'd1,
    MUL_PERIOD = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic                   en;
    mul_op_t                op;
    logic [ANGLE_MAG_W-1:0] angle;
  } mul_ctl_t;

  typedef struct packed {
    logic             start;
    logic [PIN_W-1:0] pin;
  } scan_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_SCAN       = 6'b000010,
    ST_MUL_ANGLE  = 6'b000100,
    ST_MUL_FULL   = 6'b001000,
    ST_MUL_PERIOD = 6'b010000,
    ST_DONE       = 6'b100000
  } state_t;

endpackage

/* src/scad_cmd_if.sv */
// command channel: pin and angle
interface scad_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [scad_pkg::PIN_W-1:0]    pin;
  logic signed [scad_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output pin, output angle, input ready);
  modport sink (input valid, input pin, input angle, output ready);
endinterface

/* src/scad_res_if.sv */
// result channel: status, channel, duty and echoes
interface scad_res_if;
  logic                                 valid;
  logic                                 ready;
  logic        [scad_pkg::STATUS_W-1:0] status;
  logic        [scad_pkg::CHAN_W-1:0]   channel;
  logic        [scad_pkg::DUTY_W-1:0]   duty;
  logic        [scad_pkg::PIN_W-1:0]    pin_echo;
  logic signed [scad_pkg::ANGLE_W-1:0]  angle_echo;

  modport source (output valid, output status, output channel, output duty,
                  output pin_echo, output angle_echo, input ready);
  modport sink (input valid, input status, input channel, input duty,
                input pin_echo, input angle_echo, output ready);
endinterface

/* src/servo_channel_allocate_and_duty_unit.sv */
// top level of the servo channel allocate and duty unit
// Each command transfer carries a pin and a signed angle and yields exactly one
// result transfer. An angle outside 0..180 gives status 1 at once (the sequencer
// goes straight to its done state) and leaves the channel table alone. Otherwise the table
// is scanned one entry per cycle: the first busy channel bound to the same pin
// is reused, else the lowest free channel is taken and the pin stored there; a
// full table gives status 2. A good command then makes three passes through one
// shared multiplier (angle to pulse, pulse times 8191, divide by the 20000 us
// period by reciprocal) and the result is loaded into the output register.
// A good command goes through the channel scan and the three multiplier passes
// before its result is loaded, which waits until the output register is free.
// Only one command is in flight; the next is taken once the result is loaded,
// even while it still waits to be transferred. Bindings persist until reset,
// and an error result carries zero channel and duty.
module servo_channel_allocate_and_duty_unit #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  scad_cmd_if.sink   cmd,
  scad_res_if.source res
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  scad_pkg::state_t                    state;
  scad_pkg::status_t                   status_q;
  logic        [scad_pkg::PIN_W-1:0]   pin_q;
  logic signed [scad_pkg::ANGLE_W-1:0] angle_q;
  logic        [scad_pkg::CHAN_W-1:0]  chan_q;
  logic                                ang_ok;
  logic                                load;

  // output register
  logic                                 res_valid;
  logic        [scad_pkg::STATUS_W-1:0] res_status;
  logic        [scad_pkg::CHAN_W-1:0]   res_channel;
  logic        [scad_pkg::DUTY_W-1:0]   res_duty;
  logic        [scad_pkg::PIN_W-1:0]    res_pin;
  logic signed [scad_pkg::ANGLE_W-1:0]  res_angle;

  scad_pkg::scan_req_t          scan_req;
  scad_pkg::scan_rsp_t          scan_rsp;
  logic [IDX_W-1:0]             scan_index;
  scad_pkg::mul_ctl_t           mul_ctl;
  logic [scad_pkg::PROD_W-1:0]  prod;

  // non-negative and no more than the limit
  assign ang_ok = !cmd.angle[scad_pkg::ANGLE_W-1]
               && (cmd.angle[scad_pkg::ANGLE_W-2:0]
                   <= (scad_pkg::ANGLE_W-1)'(scad_pkg::ANGLE_LIMIT));

  assign cmd.ready = (state == scad_pkg::ST_IDLE);

  // table lookup starts on the transfer itself
  assign scan_req.start = cmd.valid && cmd.ready && ang_ok;
  assign scan_req.pin   = cmd.pin;

  // multiplier sequencing follows the state
  always_comb begin
    mul_ctl.angle = angle_q[scad_pkg::ANGLE_MAG_W-1:0];
    mul_ctl.en    = 1'b1;
    case (state)
      scad_pkg::ST_MUL_ANGLE:  mul_ctl.op = scad_pkg::MUL_ANGLE;
      scad_pkg::ST_MUL_FULL:   mul_ctl.op = scad_pkg::MUL_FULL;
      scad_pkg::ST_MUL_PERIOD: mul_ctl.op = scad_pkg::MUL_PERIOD;
      default: begin
        mul_ctl.op = scad_pkg::MUL_ANGLE;
        mul_ctl.en = 1'b0;
      end
    endcase
  end

  // result leaves once the output register is free
  assign load = (state == scad_pkg::ST_DONE) && (!res_valid || res.ready);

  scad_chan #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_chan (
    .clk   (clk),
    .rst   (rst),
    .req   (scan_req),
    .rsp   (scan_rsp),
    .index (scan_index)
  );

  scad_mul u_mul (
    .clk  (clk),
    .ctl  (mul_ctl),
    .prod (prod)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scad_pkg::ST_IDLE;
    end else begin
      case (state)
        scad_pkg::ST_IDLE: begin
          if (cmd.valid) begin
            pin_q   <= cmd.pin;
            angle_q <= cmd.angle;
            if (ang_ok) begin
              state <= scad_pkg::ST_SCAN;
            end else begin
              status_q <= scad_pkg::STATUS_RANGE;
              state    <= scad_pkg::ST_DONE;
            end
          end
        end
        scad_pkg::ST_SCAN: begin
          if (scan_rsp.done) begin
            if (scan_rsp.found) begin
              chan_q   <= scad_pkg::CHAN_W'(scan_index);
              status_q <= scad_pkg::STATUS_OK;
              state    <= scad_pkg::ST_MUL_ANGLE;
            end else begin
              status_q <= scad_pkg::STATUS_EXHAUSTED;
              state    <= scad_pkg::ST_DONE;
            end
          end
        end
        scad_pkg::ST_MUL_ANGLE:  state <= scad_pkg::ST_MUL_FULL;
        scad_pkg::ST_MUL_FULL:   state <= scad_pkg::ST_MUL_PERIOD;
        scad_pkg::ST_MUL_PERIOD: state <= scad_pkg::ST_DONE;
        scad_pkg::ST_DONE: begin
          if (load) begin
            state <= scad_pkg::ST_IDLE;
          end
        end
        default: state <= scad_pkg::ST_IDLE;
      endcase
    end
  end

  // output register and its valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= status_q;
      res_pin    <= pin_q;
      res_angle  <= angle_q;
      if (status_q == scad_pkg::STATUS_OK) begin
        res_channel <= chan_q;
        res_duty    <= scad_pkg::DUTY_W'(prod >> scad_pkg::PERIOD_SHIFT);
      end else begin
        res_channel <= '0;
        res_duty    <= '0;
      end
    end
  end

  assign res.valid      = res_valid;
  assign res.status     = res_status;
  assign res.channel    = res_channel;
  assign res.duty       = res_duty;
  assign res.pin_echo   = res_pin;
  assign res.angle_echo = res_angle;

endmodule

/* src/scad_chan.sv */
// channel table with one-entry-per-cycle lookup and allocation
module scad_chan #(
  parameter int NUM_CHANNELS = 8,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scad_pkg::scan_req_t  req,
  output scad_pkg::scan_rsp_t  rsp,
  output logic [IDX_W-1:0]     index
);

  logic [NUM_CHANNELS-1:0]    busy;
  logic [scad_pkg::PIN_W-1:0] pins [NUM_CHANNELS];
  logic [scad_pkg::PIN_W-1:0] pin_q;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           free_idx;
  logic [IDX_W-1:0]           alloc_idx;
  logic                       scanning;
  logic                       have_free;
  logic                       cur_busy;
  logic                       cur_match;
  logic                       last;
  logic                       alloc;

  assign cur_busy  = busy[idx];
  assign cur_match = cur_busy && (pins[idx] == pin_q);
  assign last      = (idx == IDX_W'(NUM_CHANNELS - 1));
  assign alloc_idx = have_free ? free_idx : idx;
  // end of table, no match, some entry free
  assign alloc     = scanning && !cur_match && last && (have_free || !cur_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      scanning  <= 1'b0;
      have_free <= 1'b0;
      rsp       <= '0;
    end else begin
      if (req.start) begin
        rsp.done  <= 1'b0;
        scanning  <= 1'b1;
        have_free <= 1'b0;
        idx       <= '0;
        pin_q     <= req.pin;
      end else if (scanning) begin
        if (cur_match) begin
          scanning  <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= 1'b1;
          index     <= idx;
        end else if (last) begin
          scanning  <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= alloc;
          index     <= alloc_idx;
          if (alloc) begin
            busy[alloc_idx] <= 1'b1;
          end
        end else begin
          rsp.done <= 1'b0;
          if (!cur_busy && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          idx <= idx + IDX_W'(1);
        end
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end

  // pin store, read only where busy is set
  always_ff @(posedge clk) begin
    if (alloc) begin
      pins[alloc_idx] <= pin_q;
    end
  end

endmodule

/* src/scad_mul.sv */
// shared multiplier with operand selection for the pulse and duty chain
module scad_mul (
  input  logic                          clk,
  input  scad_pkg::mul_ctl_t            ctl,
  output logic [scad_pkg::PROD_W-1:0]   prod
);

  logic [scad_pkg::MUL_A_W-1:0] a;
  logic [scad_pkg::MUL_B_W-1:0] b;
  logic [scad_pkg::PULSE_W-1:0] pulse;

  // pulse width in us from the previous product
  assign pulse = scad_pkg::PULSE_W'(scad_pkg::PULSE_MIN)
               + scad_pkg::PULSE_W'(prod >> scad_pkg::ANGLE_SHIFT);

  always_comb begin
    case (ctl.op)
      scad_pkg::MUL_ANGLE: begin
        a = scad_pkg::MUL_A_W'(ctl.angle);
        b = scad_pkg::MUL_B_W'(scad_pkg::ANGLE_RECIP);
      end
      scad_pkg::MUL_FULL: begin
        a = scad_pkg::MUL_A_W'(pulse);
        b = scad_pkg::MUL_B_W'(scad_pkg::DUTY_FULL);
      end
      scad_pkg::MUL_PERIOD: begin
        a = prod[scad_pkg::MUL_A_W-1:0];
        b = scad_pkg::MUL_B_W'(scad_pkg::PERIOD_RECIP);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod <= scad_pkg::PROD_W'(a) * scad_pkg::PROD_W'(b);
    end
  end

endmodule

/* src/scad_chk.sv */
// port-level checker for the servo channel unit and its bind
`include "servo_channel_allocate_and_duty_unit_defines.svh"

module scad_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [scad_pkg::STATUS_W-1:0] res_status,
  input logic [scad_pkg::CHAN_W-1:0]   res_channel,
  input logic [scad_pkg::DUTY_W-1:0]   res_duty
);

  // a waiting result is not withdrawn
  `SCAD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)

  // one command in flight: ready drops after a transfer
  `SCAD_ASSERT_NEXT(a_one_in_flight, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // error results carry no channel and no duty
  `SCAD_ASSERT_NOW(a_err_zero, clk, rst,
    res_valid && (res_status != scad_pkg::STATUS_OK),
    (res_channel == '0) && (res_duty == '0))

  // a good result has at least the minimum pulse duty
  `SCAD_ASSERT_NOW(a_ok_duty, clk, rst,
    res_valid && (res_status == scad_pkg::STATUS_OK),
    res_duty >= scad_pkg::DUTY_W'(scad_pkg::DUTY_MIN))

endmodule

bind servo_channel_allocate_and_duty_unit scad_chk u_scad_chk (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_status  (res.status),
  .res_channel (res.channel),
  .res_duty    (res.duty)
);

/* tb/sv/testbench.sv */
// self-checking testbench of the servo channel allocate and duty unit
module testbench;
  import scad_pkg::*;

  // channel count of the unit under test and of the binding table kept here
  localparam int NUM_CH = 8;
  // pulse span in microseconds for 0..180 degrees, and the 50 Hz frame period
  localparam int PULSE_SPAN_US = 2000;
  localparam int FRAME_US      = 20000;
  // cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_CMDS = 900;

  typedef struct {
    status_t                   status;
    logic [CHAN_W-1:0]         channel;
    logic [DUTY_W-1:0]         duty;
    logic [PIN_W-1:0]          pin_echo;
    logic signed [ANGLE_W-1:0] angle_echo;
  } servo_result_t;

  // binding table mirror plus the queue of results still owed by the unit
  class servo_scoreboard;
    logic [PIN_W-1:0] bound_pin [NUM_CH];
    bit               bound [NUM_CH];
    servo_result_t    owed_q [$];
    int               errors;
    int               n_ok;
    int               n_range;
    int               n_full;

    function new();
      foreach (bound[c]) bound[c] = 1'b0;
      errors  = 0;
      n_ok    = 0;
      n_range = 0;
      n_full  = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function int duty_count(int deg);
      int pulse;
      pulse = PULSE_MIN + PULSE_SPAN_US * deg / ANGLE_LIMIT;
      return pulse * DUTY_FULL / FRAME_US;
    endfunction

    // random pin already bound to a channel, or any pin while the table is empty
    function logic [PIN_W-1:0] pick_bound_pin();
      int used [$];
      foreach (bound[c]) if (bound[c]) used.push_back(c);
      if (used.size() == 0) return PIN_W'($urandom_range(0, 63));
      return bound_pin[used[$urandom_range(0, used.size() - 1)]];
    endfunction

    // command transfer seen: update the table and queue the result it owes
    function void note_command(logic [PIN_W-1:0] pin, logic signed [ANGLE_W-1:0] angle);
      servo_result_t r;
      int            slot;
      r.status     = STATUS_OK;
      r.channel    = '0;
      r.duty       = '0;
      r.pin_echo   = pin;
      r.angle_echo = angle;
      slot         = -1;
      if (angle < 0 || angle > ANGLE_LIMIT) begin
        // bad angle: table untouched
        r.status = STATUS_RANGE;
        n_range++;
      end else begin
        // reuse a channel already bound to this pin
        for (int c = 0; c < NUM_CH; c++)
          if (slot < 0 && bound[c] && bound_pin[c] == pin) slot = c;
        // else claim the lowest free channel
        for (int c = 0; c < NUM_CH; c++)
          if (slot < 0 && !bound[c]) begin
            slot         = c;
            bound[c]     = 1'b1;
            bound_pin[c] = pin;
          end
        if (slot < 0) begin
          r.status = STATUS_EXHAUSTED;
          n_full++;
        end else begin
          r.channel = CHAN_W'(slot);
          r.duty    = DUTY_W'(duty_count(int'(angle)));
          n_ok++;
        end
      end
      owed_q.push_back(r);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // result transfer seen: compare with the oldest owed result
    function void check_result(servo_result_t got);
      servo_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d channel %0d",
                 $time, got.status, got.channel);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      field_check("status", int'(want.status), int'(got.status));
      field_check("channel", int'(want.channel), int'(got.channel));
      field_check("duty", int'(want.duty), int'(got.duty));
      field_check("pin_echo", int'(want.pin_echo), int'(got.pin_echo));
      field_check("angle_echo", int'(want.angle_echo), int'(got.angle_echo));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  // set during stretches where neither side idles
  bit   quiet = 1'b0;
  int   idle_cycles;
  servo_scoreboard sb;

  scad_cmd_if cmd_ch ();
  scad_res_if res_ch ();

  servo_channel_allocate_and_duty_unit #(
    .NUM_CHANNELS(NUM_CH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  always #2 clk = ~clk;

  // present one command and hold it until the transfer; valid stays high
  // across back-to-back commands so it is never dropped and raised in one step
  task automatic send_cmd(input logic [PIN_W-1:0] pin, input logic signed [ANGLE_W-1:0] angle);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.pin   <= pin;
    cmd_ch.angle <= angle;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // both transfers are sampled at the edge, so predictions see pre-edge values
  always @(posedge clk) begin
    servo_result_t got;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) sb.note_command(cmd_ch.pin, cmd_ch.angle);
      if (res_ch.valid && res_ch.ready) begin
        got.status     = status_t'(res_ch.status);
        got.channel    = res_ch.channel;
        got.duty       = res_ch.duty;
        got.pin_echo   = res_ch.pin_echo;
        got.angle_echo = res_ch.angle_echo;
        sb.check_result(got);
      end
    end
  end

  // hang detection: any transfer restarts the count
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, HANG_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: random back-pressure before each result, none in quiet stretches
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin : stimulus
    logic [PIN_W-1:0]          pin;
    logic signed [ANGLE_W-1:0] angle;
    sb = new();
    rst          <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.pin   <= '0;
    cmd_ch.angle <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: first bindings, reuse, angle extremes and bad angles
    send_cmd(6'd63, 10'sd0);
    send_cmd(6'd0, 10'sd180);
    send_cmd(6'd63, 10'sd90);
    send_cmd(6'd42, -10'sd1);
    send_cmd(6'd21, 10'sd181);
    send_cmd(6'd5, -10'sd512);
    send_cmd(6'd10, 10'sd511);
    send_cmd(6'd0, 10'sd1);
    // fill the rest of the table
    for (int k = 1; k <= 6; k++) send_cmd(PIN_W'(k), ANGLE_W'(30 * k - 1));
    // full table: new pins are refused, bad angle still wins, bound pins still served
    send_cmd(6'd7, 10'sd45);
    send_cmd(6'd10, 10'sd0);
    send_cmd(6'd7, 10'sd200);
    send_cmd(6'd6, 10'sd180);
    send_cmd(6'd63, 10'sd179);

    // random: mostly bound pins with good angles, the rest any pin or any angle
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      quiet = ((i / 150) % 3) == 1;
      if ($urandom_range(0, 99) < 60) pin = sb.pick_bound_pin();
      else pin = PIN_W'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 75) angle = ANGLE_W'($urandom_range(0, ANGLE_LIMIT));
      else angle = ANGLE_W'($urandom_range(0, 1023));
      send_cmd(pin, angle);
    end
    quiet = 1'b0;
    cmd_ch.valid <= 1'b0;

    // one more edge so the last command transfer is on the scoreboard
    @(posedge clk);
    // drain, then allow a scan plus multiplier passes for anything stray
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_CH + 8) @(posedge clk);

    $display("commands: %0d served, %0d bad angle, %0d refused with the table full",
             sb.n_ok, sb.n_range, sb.n_full);
    $display("mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
